// ----- hdl/lcfs_pkg.sv -----
// ----------------------------------------------------------------------------
// lcfs_pkg
// Shared types, sizes and codes of the LED column frame serializer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcfs_pkg;

  // Grid size. The address, column and step widths below are derived from these two.
  localparam int COLUMNS         = 64;
  localparam int LEDS_PER_COLUMN = 32;

  localparam int PIXELS = COLUMNS * LEDS_PER_COLUMN;
  localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  // The frame step runs from the start word through the end word.
  localparam int STEP_W = $clog2(LEDS_PER_COLUMN + 2);

  localparam int CMDQ_DEPTH = 2;
  localparam int OUTQ_DEPTH = 4;

  // Opcodes of an input beat.
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_COMMIT = 2'd1;
  localparam logic [1:0] OP_SHOW   = 2'd2;

  // Frame constants.
  localparam logic [7:0]  LED_HEADER = 8'hE0;
  localparam logic [7:0]  END_BYTE   = 8'hFF;
  localparam logic [31:0] START_WORD = 32'h0000_0000;
  localparam logic [2:0]  WORD_BYTES = 3'd4;
  localparam logic [2:0]  END_BYTES  = 3'd1;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_COMMIT = 2'd1,
    CMD_SHOW   = 2'd2
  } cmd_kind_t;

  typedef enum logic [1:0] {
    WK_START = 2'd0,
    WK_LED   = 2'd1,
    WK_END   = 2'd2
  } word_kind_t;

  typedef struct packed {
    logic [4:0] brightness;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] column;
    logic [4:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [4:0] brightness;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] frame_word;
    logic [2:0]  byte_count;
    logic        last;
  } out_beat_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [ADDR_W-1:0] addr;
    pixel_t            pixel;
  } cmd_t;

endpackage

`default_nettype wire

// ----- hdl/lcfs_ram.sv -----
// ----------------------------------------------------------------------------
// lcfs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfs_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 2,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hdl/lcfs_front.sv -----
// ----------------------------------------------------------------------------
// lcfs_front
// Accepts input beats, decodes them into commands and drops the no-ops.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lcfs_pkg::in_beat_t in_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output lcfs_pkg::cmd_t    cmd_data
);
  import lcfs_pkg::*;

  cmd_t cls;
  logic keep;
  logic accept;
  logic f_valid_r, f_valid_nxt;
  cmd_t f_cmd_r;

  // Decode. A write outside the grid and the unused opcode are dropped here.
  always_comb begin
    cls.addr = ADDR_W'(int'(in_data.column) * LEDS_PER_COLUMN + int'(in_data.led_index));
    cls.pixel.brightness = in_data.brightness;
    cls.pixel.blue       = in_data.blue;
    cls.pixel.green      = in_data.green;
    cls.pixel.red        = in_data.red;
    case (in_data.opcode)
      OP_WRITE: begin
        cls.kind = CMD_WRITE;
        keep = (int'(in_data.column) < COLUMNS) && (int'(in_data.led_index) < LEDS_PER_COLUMN);
      end
      OP_COMMIT: begin
        cls.kind = CMD_COMMIT;
        keep     = 1'b1;
      end
      OP_SHOW: begin
        cls.kind = CMD_SHOW;
        keep     = 1'b1;
      end
      default: begin
        cls.kind = CMD_WRITE;
        keep     = 1'b0;
      end
    endcase
  end

  assign in_ready    = !f_valid_r || cmd_ready;
  assign accept      = in_valid && in_ready;
  assign f_valid_nxt = accept ? keep : (f_valid_r && !cmd_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
    if (accept && keep) begin
      f_cmd_r <= cls;
    end
  end

  assign cmd_valid = f_valid_r;
  assign cmd_data  = f_cmd_r;

endmodule

`default_nettype wire

// ----- hdl/lcfs_cmdq.sv -----
// ----------------------------------------------------------------------------
// lcfs_cmdq
// Short command queue between the decoder and the frame engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfs_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  lcfs_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output lcfs_pkg::cmd_t pop_data
);
  import lcfs_pkg::*;

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             mem_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = (cnt_r != CNT_W'(CMDQ_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rp_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/lcfs_back.sv -----
// ----------------------------------------------------------------------------
// lcfs_back
// Frame engine: pixel stores, commit copy sweep and column frame sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  lcfs_pkg::cmd_t      cmd_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lcfs_pkg::out_beat_t out_data
);
  import lcfs_pkg::*;

  localparam int OQ_PTR_W = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;
  localparam int OQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_SHOW  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [ADDR_W-1:0] sw_r, sw_nxt;
  logic              wb_valid_r, wb_valid_nxt;
  logic [ADDR_W-1:0] wb_addr_r;
  logic              b_valid_r, b_valid_nxt;
  word_kind_t        b_kind_r, issue_kind;
  logic              issue, issue_ok;

  logic              stg_we, stg_re, dsp_re;
  logic [ADDR_W-1:0] stg_raddr, dsp_raddr;
  pixel_t            stg_rdata, dsp_rdata;

  out_beat_t            oq_mem_r [OUTQ_DEPTH];
  logic [OQ_PTR_W-1:0]  oq_wp_r, oq_wp_nxt, oq_rp_r, oq_rp_nxt;
  logic [OQ_CNT_W-1:0]  oq_cnt_r, oq_cnt_nxt;
  logic                 oq_push, oq_pop;
  out_beat_t            res;

  // Staging store: written by pixel writes, read by the commit sweep.
  lcfs_ram #(.WIDTH($bits(pixel_t)), .DEPTH(PIXELS)) u_stg_ram (
    .clk   (clk),
    .we    (stg_we),
    .waddr (cmd_data.addr),
    .wdata (cmd_data.pixel),
    .re    (stg_re),
    .raddr (stg_raddr),
    .rdata (stg_rdata)
  );

  // Display store: written in the cycle after the sweep reads each entry, read by the frame.
  lcfs_ram #(.WIDTH($bits(pixel_t)), .DEPTH(PIXELS)) u_dsp_ram (
    .clk   (clk),
    .we    (wb_valid_r),
    .waddr (wb_addr_r),
    .wdata (stg_rdata),
    .re    (dsp_re),
    .raddr (dsp_raddr),
    .rdata (dsp_rdata)
  );

  // A word may be issued only if the output queue can still take it together
  // with the word already in flight through the read stage.
  assign issue_ok  = (int'(oq_cnt_r) + int'(b_valid_r)) < OUTQ_DEPTH;
  assign stg_raddr = sw_r;
  // LEDs go out from the highest down to LED 0.
  assign dsp_raddr = ADDR_W'(int'(col_r) * LEDS_PER_COLUMN + LEDS_PER_COLUMN - int'(step_r));

  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    step_nxt     = step_r;
    sw_nxt       = sw_r;
    cmd_ready    = 1'b0;
    stg_we       = 1'b0;
    stg_re       = 1'b0;
    dsp_re       = 1'b0;
    issue        = 1'b0;
    issue_kind   = WK_START;
    wb_valid_nxt = (state_r == ST_SWEEP);
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_ready = 1'b1;
          case (cmd_data.kind)
            CMD_WRITE: begin
              stg_we = 1'b1;
            end
            CMD_COMMIT: begin
              state_nxt = ST_SWEEP;
              sw_nxt    = '0;
            end
            CMD_SHOW: begin
              state_nxt = ST_SHOW;
              step_nxt  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SWEEP: begin
        stg_re = 1'b1;
        sw_nxt = sw_r + 1'b1;
        if (sw_r == ADDR_W'(PIXELS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SHOW: begin
        if (issue_ok) begin
          issue    = 1'b1;
          step_nxt = step_r + 1'b1;
          if (step_r == '0) begin
            issue_kind = WK_START;
          end else if (step_r == STEP_W'(LEDS_PER_COLUMN + 1)) begin
            issue_kind = WK_END;
            state_nxt  = ST_IDLE;
            col_nxt    = (col_r == COL_W'(COLUMNS - 1)) ? '0 : col_r + 1'b1;
          end else begin
            issue_kind = WK_LED;
            dsp_re     = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign b_valid_nxt = issue;

  // Build the result word once the pixel read has landed.
  always_comb begin
    case (b_kind_r)
      WK_LED: begin
        res.frame_word = {LED_HEADER + 8'(dsp_rdata.brightness),
                          dsp_rdata.blue, dsp_rdata.green, dsp_rdata.red};
        res.byte_count = WORD_BYTES;
        res.last       = 1'b0;
      end
      WK_END: begin
        res.frame_word = {24'h00_0000, END_BYTE};
        res.byte_count = END_BYTES;
        res.last       = 1'b1;
      end
      default: begin
        res.frame_word = START_WORD;
        res.byte_count = WORD_BYTES;
        res.last       = 1'b0;
      end
    endcase
  end

  assign oq_push   = b_valid_r;
  assign oq_pop    = out_valid && out_ready;
  assign out_valid = (oq_cnt_r != '0);
  assign out_data  = oq_mem_r[oq_rp_r];

  always_comb begin
    oq_wp_nxt  = oq_wp_r;
    oq_rp_nxt  = oq_rp_r;
    oq_cnt_nxt = oq_cnt_r;
    if (oq_push) begin
      oq_wp_nxt = (oq_wp_r == OQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : oq_wp_r + 1'b1;
    end
    if (oq_pop) begin
      oq_rp_nxt = (oq_rp_r == OQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : oq_rp_r + 1'b1;
    end
    if (oq_push && !oq_pop) begin
      oq_cnt_nxt = oq_cnt_r + 1'b1;
    end else if (oq_pop && !oq_push) begin
      oq_cnt_nxt = oq_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      col_r      <= '0;
      step_r     <= '0;
      sw_r       <= '0;
      wb_valid_r <= 1'b0;
      b_valid_r  <= 1'b0;
      oq_wp_r    <= '0;
      oq_rp_r    <= '0;
      oq_cnt_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      col_r      <= col_nxt;
      step_r     <= step_nxt;
      sw_r       <= sw_nxt;
      wb_valid_r <= wb_valid_nxt;
      b_valid_r  <= b_valid_nxt;
      oq_wp_r    <= oq_wp_nxt;
      oq_rp_r    <= oq_rp_nxt;
      oq_cnt_r   <= oq_cnt_nxt;
    end
    wb_addr_r <= sw_r;
    if (issue) begin
      b_kind_r <= issue_kind;
    end
    if (oq_push) begin
      oq_mem_r[oq_wp_r] <= res;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/led_column_frame_serializer.sv -----
// ----------------------------------------------------------------------------
// led_column_frame_serializer
// Two-buffer pixel store for a column-scanned LED grid that streams one column
// at a time as a start word, one word per LED and an end byte.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                          Beat carries
//   --------  -----------------------------  ---------------------------------
//   input     in_valid, in_ready, in_data    opcode, pixel position and colour
//   result    out_valid, out_ready, out_data frame word, byte count, last flag
//
// A commit copies the whole staging store into the display store, one entry
// per cycle, while the engine takes no other command. A show-next produces
// LEDS_PER_COLUMN + 2 beats (34 by default), one per cycle while out_ready
// stays high; the first beat passes in turn through the decode register, the
// command queue, the read stage and the output queue.
// Reset is synchronous and clears only control state and the column pointer;
// both pixel stores hold undefined data until written, and no clearing pass
// runs. Stalls on out_ready back up through the output queue into the engine,
// and the command queue lets a few input beats be taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module led_column_frame_serializer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lcfs_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lcfs_pkg::out_beat_t out_data
);
  import lcfs_pkg::*;

  // Decoder to queue.
  logic dec_valid, dec_ready;
  cmd_t dec_cmd;

  // Queue to frame engine.
  logic eng_valid, eng_ready;
  cmd_t eng_cmd;

  // The decoder takes input beats, turns them into commands and drops the
  // ones that have no effect (an out-of-grid write or the unused opcode).
  lcfs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (dec_valid),
    .cmd_ready (dec_ready),
    .cmd_data  (dec_cmd)
  );

  // The queue keeps the decoder taking beats while the engine is busy with a
  // commit sweep or a long frame.
  lcfs_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (dec_valid),
    .push_ready (dec_ready),
    .push_data  (dec_cmd),
    .pop_valid  (eng_valid),
    .pop_ready  (eng_ready),
    .pop_data   (eng_cmd)
  );

  // The engine runs the commands strictly in order, so a write after a commit
  // never reaches the staging store before the copy is done.
  lcfs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (eng_valid),
    .cmd_ready (eng_ready),
    .cmd_data  (eng_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- hdl/lcfs_checker.sv -----
// ----------------------------------------------------------------------------
// lcfs_props
// Port-level checks of the frame stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfs_props (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input lcfs_pkg::in_beat_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input lcfs_pkg::out_beat_t out_data
);
  import lcfs_pkg::*;

  logic out_beat;
  logic want_start_r;

  assign out_beat = out_valid && out_ready;

  // Set while the next result beat must open a new column frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      want_start_r <= 1'b1;
    end else if (out_beat) begin
      want_start_r <= out_data.last;
    end
  end

  // An offered input beat holds until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input beat changed while waiting");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // The end of a column is the single end byte.
  a_end_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && out_data.last |->
      out_data.byte_count == END_BYTES && out_data.frame_word == {24'h00_0000, END_BYTE})
    else $error("malformed end beat");

  // Every other beat is a full start word or an LED word with its header bits.
  a_body_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && !out_data.last |->
      out_data.byte_count == WORD_BYTES &&
      (out_data.frame_word == START_WORD || out_data.frame_word[31:29] == 3'b111))
    else $error("malformed start or LED beat");

  // The first beat after reset and the beat after an end byte are start words.
  a_frame_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && want_start_r |-> out_data.frame_word == START_WORD && !out_data.last)
    else $error("frame order");

endmodule

bind led_column_frame_serializer lcfs_props u_lcfs_props (.*);

`default_nettype wire
